[rtl/fde_pkg.sv]
// Shared types, constants and helper functions of the FAT directory entry decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fde_pkg;

  localparam int unsigned MaxNameChunks = 20;
  localparam int unsigned ChunkChars    = 13;
  localparam int unsigned EntryW        = 256;
  localparam int unsigned ResultW       = 200;

  // one directory entry, byte 0 at index 0
  typedef logic [31:0][7:0] entry_t;

  typedef enum logic [2:0] {
    KIND_END        = 3'd0,
    KIND_DELETED    = 3'd1,
    KIND_NAME_START = 3'd2,
    KIND_NAME_NEXT  = 3'd3,
    KIND_REJECTED   = 3'd4,
    KIND_LABEL      = 3'd5,
    KIND_SHORT      = 3'd6
  } kind_e;

  localparam logic [7:0] EndMarker    = 8'h00;
  localparam logic [7:0] DeletedMark  = 8'hE5;
  localparam logic [7:0] KanjiEscape  = 8'h05;
  localparam logic [5:0] LfnAttr      = 6'h0F;
  localparam logic [7:0] QuestionMark = 8'h3F;
  localparam logic [7:0] Space        = 8'h20;
  localparam logic [7:0] Dot          = 8'h2E;

  // attribute and NT case bit positions
  localparam int unsigned AttrVolumeBit  = 3;
  localparam int unsigned AttrDirBit     = 4;
  localparam int unsigned LfnStartBit    = 6;
  localparam int unsigned NtLowerBaseBit = 3;
  localparam int unsigned NtLowerExtBit  = 4;

  // byte offsets of the 13 UCS-2 characters of a long-name chunk, slot 0 lowest
  localparam logic [12:0][4:0] ChunkSlot = {
    5'd30, 5'd28, 5'd24, 5'd22, 5'd20, 5'd18, 5'd16,
    5'd14, 5'd9,  5'd7,  5'd5,  5'd3,  5'd1
  };

  typedef struct packed {
    logic       active;
    logic [4:0] expected_order;
    logic [7:0] checksum;
    logic       first_char_written;
  } chain_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] text_low;
    logic [39:0] text_high;
    logic [7:0]  text_position;
    logic [3:0]  text_count;
    logic [7:0]  attributes;
    logic        is_directory;
    logic [31:0] file_size;
    logic [31:0] start_cluster;
    logic        long_name_ready;
  } result_t;

  // one step of the short-name checksum: rotate right, add the next byte
  function automatic logic [7:0] sum_step(logic [7:0] s, logic [7:0] b);
    return {s[0], s[7:1]} + b;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

endpackage

`default_nettype wire

[rtl/fde_csum_head.sv]
// First half of the short-name checksum (name bytes 0 to 5), computed ahead of the input register.
// Depends on fde_pkg.
`default_nettype none

module fde_csum_head
  import fde_pkg::*;
(
  input  entry_t     entry_i,
  output logic [7:0] head_sum_o
);

  always_comb begin
    head_sum_o = 8'h00;
    for (int i = 0; i < 6; i++) begin
      head_sum_o = sum_step(head_sum_o, entry_i[i]);
    end
  end

endmodule

`default_nettype wire

[rtl/fde_decode.sv]
// Classifier and field extraction for one directory entry, plus the next long-name chain state.
// Purely combinational; depends on fde_pkg.
`default_nettype none

module fde_decode
  import fde_pkg::*;
(
  input  entry_t     entry_i,
  input  logic [7:0] head_sum_i,
  input  chain_t     chain_i,
  output result_t    result_o,
  output chain_t     chain_o
);

  logic [7:0]   b0, attr, nt, lsum, csum, c, tail_sum, ord_m1;
  logic [5:0]   ord, exp_ord;
  logic         start, act, stop;
  logic [15:0]  u;
  logic [103:0] text;
  logic [31:0]  ext_str;
  logic [3:0]   cnt, bc;
  logic [1:0]   ec;

  assign b0   = entry_i[0];
  assign attr = entry_i[11];
  assign nt   = entry_i[12];
  assign lsum = entry_i[13];
  assign ord  = b0[5:0];

  // finish the checksum over name bytes 6 to 10
  always_comb begin
    tail_sum = head_sum_i;
    for (int i = 6; i < 11; i++) begin
      tail_sum = sum_step(tail_sum, entry_i[i]);
    end
  end

  always_comb begin
    result_o = '0;
    chain_o  = chain_i;
    text     = '0;
    cnt      = '0;
    bc       = '0;
    ec       = '0;
    ext_str  = '0;
    stop     = 1'b0;
    c        = '0;
    u        = '0;
    start    = b0[LfnStartBit];
    act      = start | chain_i.active;
    exp_ord  = start ? ord : {1'b0, chain_i.expected_order};
    csum     = start ? lsum : chain_i.checksum;
    ord_m1   = 8'(ord) - 8'd1;

    priority if (b0 == EndMarker) begin
      result_o.kind = KIND_END;
      chain_o       = '0;
    end else if (b0 == DeletedMark) begin
      result_o.kind = KIND_DELETED;
      chain_o       = '0;
    end else if (attr[5:0] == LfnAttr) begin
      if (!act || ord == 6'd0 || ord > 6'(MaxNameChunks) || ord != exp_ord || lsum != csum) begin
        result_o.kind = KIND_REJECTED;
        chain_o       = '0;
      end else begin
        // characters end at the first 0x0000 or 0xFFFF code unit
        for (int i = 0; i < ChunkChars; i++) begin
          u = {entry_i[5'(ChunkSlot[i] + 5'd1)], entry_i[ChunkSlot[i]]};
          if (u == 16'h0000 || u == 16'hFFFF) stop = 1'b1;
          if (!stop) begin
            text[i*8 +: 8] = (u < 16'h0080) ? u[7:0] : QuestionMark;
            cnt            = cnt + 4'd1;
          end
        end
        result_o.kind          = start ? KIND_NAME_START : KIND_NAME_NEXT;
        result_o.text_position = 8'(ord_m1 * 8'(ChunkChars));
        result_o.text_count    = cnt;
        chain_o.active         = 1'b1;
        chain_o.expected_order = ord_m1[4:0];
        chain_o.checksum       = csum;
        if (ord == 6'd1 && cnt != 4'd0) begin
          chain_o.first_char_written = 1'b1;
        end else if (start) begin
          chain_o.first_char_written = 1'b0;
        end
      end
    end else if (attr[AttrVolumeBit]) begin
      result_o.kind = KIND_LABEL;
      chain_o       = '0;
    end else begin
      // base name stops at the first space
      for (int i = 0; i < 8; i++) begin
        c = entry_i[i];
        if (c == Space) stop = 1'b1;
        if (!stop) begin
          if (i == 0 && c == KanjiEscape) c = DeletedMark;
          if (nt[NtLowerBaseBit]) c = to_lower(c);
          text[i*8 +: 8] = c;
          bc             = bc + 4'd1;
        end
      end
      cnt = bc;
      if (entry_i[8] != Space) begin
        ext_str[7:0] = Dot;
        stop         = 1'b0;
        for (int j = 0; j < 3; j++) begin
          c = entry_i[8 + j];
          if (c == Space) stop = 1'b1;
          if (!stop) begin
            if (nt[NtLowerExtBit]) c = to_lower(c);
            ext_str[(j+1)*8 +: 8] = c;
            ec                    = ec + 2'd1;
          end
        end
        text = text | (104'(ext_str) << {bc, 3'b000});
        cnt  = bc + 4'd1 + 4'(ec);
      end
      result_o.kind            = KIND_SHORT;
      result_o.text_count      = cnt;
      result_o.attributes      = attr;
      result_o.is_directory    = attr[AttrDirBit];
      result_o.file_size       = {entry_i[31], entry_i[30], entry_i[29], entry_i[28]};
      result_o.start_cluster   = {entry_i[21], entry_i[20], entry_i[27], entry_i[26]};
      result_o.long_name_ready = chain_i.active && (chain_i.expected_order == 5'd0) &&
                                 (tail_sum == chain_i.checksum) && chain_i.first_char_written;
      chain_o                  = '0;
    end

    result_o.text_low  = text[63:0];
    result_o.text_high = text[103:64];
  end

endmodule

`default_nettype wire

[rtl/fat_directory_entry_decoder.sv]
// Top level of the FAT directory entry decoder: input register, decode, result register.
// Depends on fde_pkg, fde_csum_head and fde_decode.
`default_nettype none

// Usage
// - Slave channel s_axis_*: one 32-byte directory entry per transaction, little-endian.
// - Master channel m_axis_*: exactly one result transaction per entry, in entry order.
// - Path: an accepted entry moves from the input register to the result register, and its
//   result is offered once the result register has loaded it. Throughput: one entry per
//   cycle while m_axis_tready is high, set by the single decode stage; the checksum over
//   the short name is split across the two register stages.
// - Long-name chains (start chunk counting down to order 1) are tracked across entries;
//   chain state updates when an entry moves from the input register to the result
//   register, so results always reflect strict arrival order.
// - Reset clears both valid flags and the chain state; no transaction is pending after it.
// - While a result waits and m_axis_tready is low the result register holds; the input
//   register still takes one more entry, after which s_axis_tready drops until the result is taken.
// - Every field that a result kind does not use is driven as zero.

module fat_directory_entry_decoder
  import fde_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // tdata from bit 0: entry_bytes_0_7, entry_bytes_8_15, entry_bytes_16_23, entry_bytes_24_31
  input  logic [EntryW-1:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // tdata from bit 0: kind(3), text_low(64), text_high(40), text_position(8),
  // text_count(4), attributes(8), is_directory(1), file_size(32), start_cluster(32),
  // long_name_ready(1), zero fill(7)
  output logic [ResultW-1:0] m_axis_tdata
);

  logic       in_valid_q, out_valid_q, advance;
  entry_t     entry_d, entry_q;
  logic [7:0] head_sum_d, head_sum_q;
  chain_t     chain_d, chain_q;
  result_t    res_d, res_q;

  assign entry_d = entry_t'(s_axis_tdata);

  // Result register frees up when empty or when its transaction completes.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  fde_csum_head u_csum_head (
    .entry_i    (entry_d),
    .head_sum_o (head_sum_d)
  );

  fde_decode u_decode (
    .entry_i    (entry_q),
    .head_sum_i (head_sum_q),
    .chain_i    (chain_q),
    .result_o   (res_d),
    .chain_o    (chain_d)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        // commit chain state only when an entry actually moves forward
        if (in_valid_q) begin
          chain_q <= chain_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      entry_q    <= entry_d;
      head_sum_q <= head_sum_d;
    end
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0000000, res_q.long_name_ready, res_q.start_cluster,
                          res_q.file_size, res_q.is_directory, res_q.attributes,
                          res_q.text_count, res_q.text_position, res_q.text_high,
                          res_q.text_low, res_q.kind};

  // Any entry other than an accepted chunk leaves the chain fully cleared.
  a_chain_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q &&
     (res_d.kind == KIND_SHORT || res_d.kind == KIND_END || res_d.kind == KIND_DELETED ||
      res_d.kind == KIND_LABEL || res_d.kind == KIND_REJECTED))
    |=> (chain_q == '0))
    else $error("chain state not cleared after a terminating entry");

  // An active chain always waits for an order below the chunk limit.
  a_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_q.active |-> (chain_q.expected_order < 5'(MaxNameChunks)))
    else $error("expected order out of range");

  // Only short entries report a matching long name.
  a_ready_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.long_name_ready) |-> (res_q.kind == KIND_SHORT))
    else $error("long_name_ready on a non-short entry");

  // Kinds without text carry an empty text count.
  a_no_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.kind == KIND_END || res_q.kind == KIND_DELETED ||
                     res_q.kind == KIND_LABEL || res_q.kind == KIND_REJECTED))
    |-> (res_q.text_count == 4'd0))
    else $error("text reported for a kind without text");

endmodule

`default_nettype wire
